// ===== rtl/sxc_pkg.sv =====
package sxc_pkg;

  // Field widths
  localparam int RAW_W      = 12;
  localparam int CMD_W      = 13;
  localparam int YAW_W      = 16;
  localparam int THR_W      = 11;
  localparam int HEAD_W     = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  // Internal widths
  localparam int DEFL_W    = 9;
  localparam int SEG_W     = 3;
  localparam int FRAC_W    = 7;
  localparam int CURVE_W   = 12;
  localparam int YAW_B_W   = 10;

  localparam int SXC_QUEUE_DEPTH = 2;
  localparam int CURVE_POINTS    = 7;
  localparam int SEG_STEP        = 100;

  localparam logic [DEFL_W-1:0]         DEFL_LIMIT = 9'd500;
  localparam logic [DEFL_W-1:0]         YAW_DEAD   = 9'd70;
  localparam logic [THR_W-1:0]          THR_MAX    = 11'd2000;
  localparam logic [6:0]                EXPO_MAX   = 7'd100;
  localparam logic signed [13:0]        CURVE_BASE = 14'sd2500;
  localparam logic signed [YAW_B_W-1:0] HEAD_HALF  = 10'sd180;
  localparam logic signed [YAW_B_W-1:0] HEAD_FULL  = 10'sd360;

  // floor(q / 2500) = (q * RECIP_2500) >> 35, exact for q below 2^23
  localparam logic [23:0] RECIP_2500       = 24'd13743896;
  localparam int          RECIP_2500_SHIFT = 35;
  // floor(x / 100) = (x * RECIP_100) >> 25, exact for x below 493499
  localparam logic [18:0] RECIP_100        = 19'd335545;
  localparam int          RECIP_100_SHIFT  = 25;

  typedef struct packed {
    logic [6:0]  expo_amount;
    logic [7:0]  rate_amount;
    logic [10:0] centre_width;
    logic [10:0] min_check;
    logic [5:0]  heading_gain;
  } sxc_cfg_t;

  localparam sxc_cfg_t CFG_RESET = '{
    expo_amount:  7'd65,
    rate_amount:  8'd90,
    centre_width: 11'd1500,
    min_check:    11'd1100,
    heading_gain: 6'd0
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EXPO_AMOUNT,
    REG_RATE_AMOUNT,
    REG_CENTRE_WIDTH,
    REG_MIN_CHECK,
    REG_HEADING_GAIN
  } sxc_reg_t;

  // One shaped stick as classified by the front end
  typedef struct packed {
    logic [SEG_W-1:0]  seg;
    logic [FRAC_W-1:0] frac;
    logic              neg;
  } sxc_axis_t;

  // One queued frame
  typedef struct packed {
    sxc_axis_t                  roll;
    sxc_axis_t                  pitch;
    logic signed [YAW_B_W-1:0]  yaw_base;
    logic                       hh;
    logic signed [YAW_B_W-1:0]  dif;
    logic [THR_W-1:0]           thr;
  } sxc_item_t;

  // Curve point being issued for the current frame
  typedef enum logic [1:0] {
    PH_ROLL_LO,
    PH_ROLL_HI,
    PH_PITCH_LO,
    PH_PITCH_HI
  } sxc_phase_t;

endpackage

// ===== rtl/sxc_if.sv =====
interface sxc_in_if;
  import sxc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [RAW_W-1:0]         roll_raw;
  logic [RAW_W-1:0]         pitch_raw;
  logic [RAW_W-1:0]         yaw_raw;
  logic [RAW_W-1:0]         throttle_raw;
  logic                     alt_hold;
  logic signed [HEAD_W-1:0] heading_deg;

  modport source (output valid, roll_raw, pitch_raw, yaw_raw, throttle_raw, alt_hold,
                  heading_deg, input ready);
  modport sink (input valid, roll_raw, pitch_raw, yaw_raw, throttle_raw, alt_hold,
                heading_deg, output ready);
endinterface

interface sxc_out_if;
  import sxc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [CMD_W-1:0] roll_cmd;
  logic signed [CMD_W-1:0] pitch_cmd;
  logic signed [YAW_W-1:0] yaw_cmd;
  logic [THR_W-1:0]        throttle_cmd;

  modport source (output valid, roll_cmd, pitch_cmd, yaw_cmd, throttle_cmd, input ready);
  modport sink (input valid, roll_cmd, pitch_cmd, yaw_cmd, throttle_cmd, output ready);
endinterface

interface sxc_cfg_if;
  import sxc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/stick_expo_command_shaper_unit.sv =====
// Stick expo command shaper.
// Input channel in_ch: one word per RC frame (four stick pulse widths, the
// altitude-hold flag and the current heading). Output channel out_ch: one
// word of roll, pitch, yaw and throttle commands per frame, in frame order.
// Config channel cfg_ch: register index and data, always ready; write only
// while no frame is in flight.
// The back end has a single curve-point unit, which evaluates the low and
// high point for roll and then for pitch, one point per cycle unless the
// output stalls, and takes the next frame while it issues the last one.
// The front end classifies each frame in the accepting cycle (deflections,
// curve segments, heading error, throttle clamp) and parks it in a small
// queue; in_ch.ready drops only when that queue is full.
// Reset: config registers load their defaults, the held heading and the
// last throttle clear to zero, queue and pipeline empty.
// Receiver stall: the output register holds its word and the back end
// freezes in place; the front keeps taking frames until the queue fills.
module stick_expo_command_shaper_unit #(
  parameter int QUEUE_DEPTH = sxc_pkg::SXC_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  sxc_in_if.sink     in_ch,
  sxc_out_if.source  out_ch,
  sxc_cfg_if.sink    cfg_ch
);
  import sxc_pkg::*;

  sxc_cfg_t  cfg_r;
  sxc_cfg_t  cfg_nxt;
  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_empty;
  sxc_item_t q_in;
  sxc_item_t q_out;

  // Config writes never stall
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_EXPO_AMOUNT:  cfg_nxt.expo_amount = cfg_ch.data[6:0];
        REG_RATE_AMOUNT:  cfg_nxt.rate_amount = cfg_ch.data[7:0];
        REG_CENTRE_WIDTH: cfg_nxt.centre_width = cfg_ch.data[10:0];
        REG_MIN_CHECK:    cfg_nxt.min_check = cfg_ch.data[10:0];
        REG_HEADING_GAIN: cfg_nxt.heading_gain = cfg_ch.data[5:0];
        default: begin
          // drop writes to unmapped indexes
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front: accept and classify, keep heading and throttle state
  sxc_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (q_in)
  );

  // Decoupling queue between front and back
  sxc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_out),
    .empty     (q_empty)
  );

  // Back: curve evaluation, interpolation, output register
  sxc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_empty (q_empty),
    .q_data  (q_out),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// ===== rtl/sxc_front.sv =====
module sxc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  sxc_pkg::sxc_cfg_t   cfg,
  sxc_in_if.sink              in_ch,
  input  logic                q_full,
  output logic                q_push,
  output sxc_pkg::sxc_item_t  q_item
);
  import sxc_pkg::*;

  typedef struct packed {
    logic [DEFL_W-1:0] mag;
    logic              neg;
  } sxc_defl_t;

  // Distance from centre, limited, plus which side of centre
  function automatic sxc_defl_t measure(input logic [RAW_W-1:0] raw,
                                        input logic [10:0] centre);
    logic signed [RAW_W:0] diff;
    logic [RAW_W:0]        mag;
    sxc_defl_t             res;
    diff = $signed({1'b0, raw}) - $signed({2'b00, centre});
    mag = diff[RAW_W] ? (RAW_W+1)'(-diff) : (RAW_W+1)'(diff);
    res.neg = raw < {1'b0, centre};
    res.mag = (mag > (RAW_W+1)'(DEFL_LIMIT)) ? DEFL_LIMIT : mag[DEFL_W-1:0];
    return res;
  endfunction

  // Curve segment and offset into it
  function automatic sxc_axis_t split(input sxc_defl_t d);
    sxc_axis_t         res;
    logic [DEFL_W-1:0] off;
    res.seg = '0;
    off = '0;
    for (int k = 1; k < CURVE_POINTS - 1; k++) begin
      if (d.mag >= DEFL_W'(k * SEG_STEP)) begin
        res.seg = SEG_W'(k);
        off = DEFL_W'(k * SEG_STEP);
      end
    end
    res.frac = FRAC_W'(d.mag - off);
    res.neg = d.neg;
    return res;
  endfunction

  logic                      accept;
  sxc_defl_t                 roll_d;
  sxc_defl_t                 pitch_d;
  sxc_defl_t                 yaw_d;
  logic [THR_W-1:0]          min_thr;
  logic [THR_W-1:0]          thr_clamped;
  logic                      hold_on;
  logic signed [YAW_B_W-1:0] dif_raw;
  logic signed [YAW_B_W-1:0] dif_lo;
  logic signed [YAW_B_W-1:0] dif_wrap;
  logic signed [HEAD_W-1:0]  held_heading_r;
  logic signed [HEAD_W-1:0]  held_heading_nxt;
  logic [THR_W-1:0]          last_thr_r;
  logic [THR_W-1:0]          last_thr_nxt;

  assign in_ch.ready = !q_full;
  assign accept = in_ch.valid && in_ch.ready;
  assign q_push = accept;

  always_comb begin
    roll_d = measure(in_ch.roll_raw, cfg.centre_width);
    pitch_d = measure(in_ch.pitch_raw, cfg.centre_width);
    yaw_d = measure(in_ch.yaw_raw, cfg.centre_width);

    min_thr = (cfg.min_check > THR_MAX) ? THR_MAX : cfg.min_check;
    if (in_ch.throttle_raw < {1'b0, min_thr}) begin
      thr_clamped = min_thr;
    end else if (in_ch.throttle_raw > {1'b0, THR_MAX}) begin
      thr_clamped = THR_MAX;
    end else begin
      thr_clamped = in_ch.throttle_raw[THR_W-1:0];
    end

    // Heading hold engages with yaw near centre and throttle above the check
    hold_on = (yaw_d.mag < YAW_DEAD) && (in_ch.throttle_raw > {1'b0, min_thr});

    // Wrap the heading error once into the half-open turn
    dif_raw = $signed({in_ch.heading_deg[HEAD_W-1], in_ch.heading_deg})
            - $signed({held_heading_r[HEAD_W-1], held_heading_r});
    dif_lo = (dif_raw <= -HEAD_HALF) ? dif_raw + HEAD_FULL : dif_raw;
    dif_wrap = (dif_lo >= HEAD_HALF) ? dif_lo - HEAD_FULL : dif_lo;

    held_heading_nxt = (accept && !hold_on) ? in_ch.heading_deg : held_heading_r;
    last_thr_nxt = (accept && !in_ch.alt_hold) ? thr_clamped : last_thr_r;

    q_item.roll = split(roll_d);
    q_item.pitch = split(pitch_d);
    q_item.yaw_base = yaw_d.neg ? $signed({1'b0, yaw_d.mag}) : -$signed({1'b0, yaw_d.mag});
    q_item.hh = hold_on;
    q_item.dif = dif_wrap;
    q_item.thr = last_thr_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_heading_r <= '0;
      last_thr_r <= '0;
    end else begin
      held_heading_r <= held_heading_nxt;
      last_thr_r <= last_thr_nxt;
    end
  end

endmodule

// ===== rtl/sxc_queue.sv =====
module sxc_queue #(
  parameter int DEPTH = sxc_pkg::SXC_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  sxc_pkg::sxc_item_t  push_item,
  output logic                full,
  input  logic                pop,
  output sxc_pkg::sxc_item_t  pop_item,
  output logic                empty
);
  import sxc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sxc_item_t       mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r;
  logic [PW-1:0]   rd_ptr_nxt;
  logic [CW-1:0]   cnt_r;
  logic [CW-1:0]   cnt_nxt;

  assign full = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign pop_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/sxc_back.sv =====
module sxc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  sxc_pkg::sxc_cfg_t   cfg,
  input  logic                q_empty,
  input  sxc_pkg::sxc_item_t  q_data,
  output logic                q_pop,
  sxc_out_if.source           out_ch
);
  import sxc_pkg::*;

  typedef struct packed {
    sxc_phase_t              ph;
    logic [SEG_W-1:0]        idx;
    logic [FRAC_W-1:0]       frac;
    logic                    neg;
    logic signed [YAW_W-1:0] yaw;
    logic [THR_W-1:0]        thr;
  } sxc_tag_t;

  // idx * idx - 25 for the seven curve points
  function automatic logic signed [5:0] sq_less25(input logic [SEG_W-1:0] i);
    logic signed [5:0] res;
    unique case (i)
      3'd0:    res = -6'sd25;
      3'd1:    res = -6'sd24;
      3'd2:    res = -6'sd21;
      3'd3:    res = -6'sd16;
      3'd4:    res = -6'sd9;
      3'd5:    res = 6'sd0;
      3'd6:    res = 6'sd11;
      default: res = 6'sd0;
    endcase
    return res;
  endfunction

  function automatic logic is_hi(input sxc_phase_t ph);
    return (ph == PH_ROLL_HI) || (ph == PH_PITCH_HI);
  endfunction

  logic                    back_en;
  logic                    slot_free;
  sxc_item_t               cur_r;
  sxc_item_t               cur_nxt;
  logic                    cur_valid_r;
  logic                    cur_valid_nxt;
  sxc_phase_t              ph_r;
  sxc_phase_t              ph_nxt;

  sxc_axis_t               axis;
  logic [SEG_W-1:0]        idx;
  logic [6:0]              expo_cl;
  logic signed [13:0]      expo_term;
  logic signed [13:0]      base;
  logic signed [16:0]      hold_term;
  sxc_tag_t                tag_issue;

  logic                    v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  sxc_tag_t                tag1_r, tag2_r, tag3_r, tag4_r, tag5_r, tag6_r;
  sxc_tag_t                tag2_in;
  logic [CURVE_W-1:0]      base1_r;
  logic signed [16:0]      hold1_r;
  logic                    hh1_r;
  logic [14:0]             bi2_r;
  logic [22:0]             q3_r;
  logic [46:0]             div_prod;
  logic [CURVE_W-1:0]      t4_r;
  logic [CURVE_W-1:0]      lo_r;
  logic [18:0]             x5_r;
  logic [CURVE_W-1:0]      lo5_r;
  logic [37:0]             interp_prod;
  logic [CURVE_W-1:0]      quot6_r;
  logic [CURVE_W-1:0]      lo6_r;
  logic [CURVE_W-1:0]      mag;
  logic signed [CMD_W-1:0] cmd;
  logic signed [YAW_W-1:0] yaw2;

  logic                    out_valid_r;
  logic signed [CMD_W-1:0] out_roll_r;
  logic signed [CMD_W-1:0] out_pitch_r;
  logic signed [YAW_W-1:0] out_yaw_r;
  logic [THR_W-1:0]        out_thr_r;
  logic signed [CMD_W-1:0] roll_hold_r;

  // Whole back end freezes while a finished word waits at the output
  assign back_en = !out_valid_r || out_ch.ready;
  assign slot_free = !cur_valid_r || (ph_r == PH_PITCH_HI);

  // Sequencer: four curve points per frame, one per cycle while the back end is not frozen
  always_comb begin
    q_pop = back_en && slot_free && !q_empty;
    cur_nxt = cur_r;
    cur_valid_nxt = cur_valid_r;
    ph_nxt = ph_r;
    if (back_en) begin
      if (q_pop) begin
        cur_nxt = q_data;
        cur_valid_nxt = 1'b1;
        ph_nxt = PH_ROLL_LO;
      end else if (cur_valid_r) begin
        if (ph_r == PH_PITCH_HI) begin
          cur_valid_nxt = 1'b0;
        end else begin
          ph_nxt = sxc_phase_t'(ph_r + 2'd1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      ph_r <= PH_ROLL_LO;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      ph_r <= ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  // Issue: curve base term for the selected point
  always_comb begin
    axis = ((ph_r == PH_PITCH_LO) || (ph_r == PH_PITCH_HI)) ? cur_r.pitch : cur_r.roll;
    idx = axis.seg + SEG_W'(is_hi(ph_r));
    expo_cl = (cfg.expo_amount > EXPO_MAX) ? EXPO_MAX : cfg.expo_amount;
    expo_term = $signed({1'b0, expo_cl}) * sq_less25(idx);
    base = CURVE_BASE + expo_term;
    hold_term = cur_r.dif * $signed({1'b0, cfg.heading_gain});
    tag_issue.ph = ph_r;
    tag_issue.idx = idx;
    tag_issue.frac = axis.frac;
    tag_issue.neg = axis.neg;
    tag_issue.yaw = {{(YAW_W-YAW_B_W){cur_r.yaw_base[YAW_B_W-1]}}, cur_r.yaw_base};
    tag_issue.thr = cur_r.thr;
  end

  assign yaw2 = hh1_r ? tag1_r.yaw + $signed(hold1_r[YAW_W-1:0]) : tag1_r.yaw;
  assign div_prod = 47'(q3_r) * 47'(RECIP_2500);
  assign interp_prod = 38'(x5_r) * 38'(RECIP_100);

  // Carry the tag on with the heading correction folded into yaw
  always_comb begin
    tag2_in = tag1_r;
    tag2_in.yaw = yaw2;
  end

  // Final add and sign restore
  always_comb begin
    mag = lo6_r + quot6_r;
    cmd = tag6_r.neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (back_en) begin
      v1_r <= cur_valid_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r && is_hi(tag4_r.ph);
      v6_r <= v5_r;
      out_valid_r <= v6_r && (tag6_r.ph == PH_PITCH_HI);
    end
  end

  always_ff @(posedge clk) begin
    if (back_en) begin
      // stage 1: base term, heading correction product
      tag1_r <= tag_issue;
      base1_r <= base[CURVE_W-1:0];
      hold1_r <= hold_term;
      hh1_r <= cur_r.hh;
      // stage 2: scale by point index, fold in heading hold
      tag2_r <= tag2_in;
      bi2_r <= 15'(base1_r) * 15'(tag1_r.idx);
      // stage 3: scale by rate
      tag3_r <= tag2_r;
      q3_r <= 23'(bi2_r) * 23'(cfg.rate_amount);
      // stage 4: divide by 2500
      tag4_r <= tag3_r;
      t4_r <= div_prod[RECIP_2500_SHIFT+CURVE_W-1:RECIP_2500_SHIFT];
      if (v4_r && !is_hi(tag4_r.ph)) begin
        lo_r <= t4_r;
      end
      // stage 5: offset times slope
      tag5_r <= tag4_r;
      x5_r <= 19'(tag4_r.frac) * 19'(t4_r - lo_r);
      lo5_r <= lo_r;
      // stage 6: divide by segment width
      tag6_r <= tag5_r;
      quot6_r <= interp_prod[RECIP_100_SHIFT+CURVE_W-1:RECIP_100_SHIFT];
      lo6_r <= lo5_r;
      // output: park roll, emit word with pitch
      if (v6_r && (tag6_r.ph == PH_ROLL_HI)) begin
        roll_hold_r <= cmd;
      end
      if (v6_r && (tag6_r.ph == PH_PITCH_HI)) begin
        out_roll_r <= roll_hold_r;
        out_pitch_r <= cmd;
        out_yaw_r <= tag6_r.yaw;
        out_thr_r <= tag6_r.thr;
      end
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.roll_cmd = out_roll_r;
  assign out_ch.pitch_cmd = out_pitch_r;
  assign out_ch.yaw_cmd = out_yaw_r;
  assign out_ch.throttle_cmd = out_thr_r;

endmodule

// ===== dv/shaper_checker.sv =====
`timescale 1ns / 1ps

module shaper_checker (
  input  logic clk,
  input  logic rst_n,
  sxc_in_if    in_mon,
  sxc_out_if   out_mon,
  sxc_cfg_if   cfg_mon,
  output int   fail_count,
  output int   pending
);
  import sxc_pkg::*;

  localparam int CURVE_SCALE = 2500;
  localparam int EXPO_PIVOT  = 25;
  localparam int HALF_TURN   = 180;
  localparam int FULL_TURN   = 360;

  typedef struct packed {
    logic signed [CMD_W-1:0] roll;
    logic signed [CMD_W-1:0] pitch;
    logic signed [YAW_W-1:0] yaw;
    logic [THR_W-1:0]        thr;
  } shaped_cmd_t;

  sxc_cfg_t                 cur_cfg;
  logic signed [HEAD_W-1:0] held_heading;
  logic [THR_W-1:0]         last_throttle;
  shaped_cmd_t              cmd_backlog[$];
  int                       errors = 0;

  function automatic int curve_pt(int i, sxc_cfg_t c);
    int e;
    e = (c.expo_amount > EXPO_MAX) ? int'(EXPO_MAX) : int'(c.expo_amount);
    return (CURVE_SCALE + e * (i * i - EXPO_PIVOT)) * i * int'(c.rate_amount) / CURVE_SCALE;
  endfunction

  function automatic int stick_defl(logic [RAW_W-1:0] raw, sxc_cfg_t c);
    int d;
    d = int'(raw) - int'(c.centre_width);
    if (d < 0) d = -d;
    if (d > int'(DEFL_LIMIT)) d = int'(DEFL_LIMIT);
    return d;
  endfunction

  function automatic int shape_stick(logic [RAW_W-1:0] raw, sxc_cfg_t c);
    int d, seg, lo, hi, v;
    d   = stick_defl(raw, c);
    seg = d / SEG_STEP;
    lo  = curve_pt(seg, c);
    hi  = curve_pt((seg + 1 < CURVE_POINTS) ? seg + 1 : CURVE_POINTS - 1, c);
    v   = lo + (d - seg * SEG_STEP) * (hi - lo) / SEG_STEP;
    if (raw < c.centre_width) v = -v;
    return v;
  endfunction

  // Shape the frame on the input channel and queue the commands it must give.
  task automatic shape_frame();
    int          rc, pc, yc, dif, mc;
    shaped_cmd_t cmd;
    mc = (cur_cfg.min_check > THR_MAX) ? int'(THR_MAX) : int'(cur_cfg.min_check);
    rc = shape_stick(in_mon.roll_raw, cur_cfg);
    pc = shape_stick(in_mon.pitch_raw, cur_cfg);
    yc = -stick_defl(in_mon.yaw_raw, cur_cfg);
    if (in_mon.yaw_raw < cur_cfg.centre_width) yc = -yc;

    if (!in_mon.alt_hold) begin
      if (int'(in_mon.throttle_raw) < mc) last_throttle = mc[THR_W-1:0];
      else if (in_mon.throttle_raw > THR_MAX) last_throttle = THR_MAX;
      else last_throttle = in_mon.throttle_raw[THR_W-1:0];
    end

    if (yc < int'(YAW_DEAD) && yc > -int'(YAW_DEAD) && int'(in_mon.throttle_raw) > mc) begin
      dif = int'(in_mon.heading_deg) - int'(held_heading);
      if (dif <= -HALF_TURN) dif += FULL_TURN;
      if (dif >= HALF_TURN) dif -= FULL_TURN;
      yc += dif * int'(cur_cfg.heading_gain);
    end else begin
      held_heading = in_mon.heading_deg;
    end

    cmd.roll  = rc[CMD_W-1:0];
    cmd.pitch = pc[CMD_W-1:0];
    cmd.yaw   = yc[YAW_W-1:0];
    cmd.thr   = last_throttle;
    cmd_backlog.push_back(cmd);
  endtask

  task automatic report(string msg);
    $display("%0t: %s", $time, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    shaped_cmd_t want;
    if (!rst_n) begin
      cur_cfg       = CFG_RESET;
      held_heading  = '0;
      last_throttle = '0;
      cmd_backlog.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) shape_frame();

      if (out_mon.valid && out_mon.ready) begin
        if (cmd_backlog.size() == 0) begin
          report($sformatf("unexpected word roll %0d pitch %0d yaw %0d thr %0d",
                           out_mon.roll_cmd, out_mon.pitch_cmd, out_mon.yaw_cmd,
                           out_mon.throttle_cmd));
        end else begin
          want = cmd_backlog.pop_front();
          if (out_mon.roll_cmd !== want.roll)
            report($sformatf("roll_cmd %0d, want %0d", out_mon.roll_cmd, want.roll));
          if (out_mon.pitch_cmd !== want.pitch)
            report($sformatf("pitch_cmd %0d, want %0d", out_mon.pitch_cmd, want.pitch));
          if (out_mon.yaw_cmd !== want.yaw)
            report($sformatf("yaw_cmd %0d, want %0d", out_mon.yaw_cmd, want.yaw));
          if (out_mon.throttle_cmd !== want.thr)
            report($sformatf("throttle_cmd %0d, want %0d", out_mon.throttle_cmd, want.thr));
        end
      end

      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_EXPO_AMOUNT:  cur_cfg.expo_amount  = cfg_mon.data[6:0];
          REG_RATE_AMOUNT:  cur_cfg.rate_amount  = cfg_mon.data[7:0];
          REG_CENTRE_WIDTH: cur_cfg.centre_width = cfg_mon.data;
          REG_MIN_CHECK:    cur_cfg.min_check    = cfg_mon.data;
          REG_HEADING_GAIN: cur_cfg.heading_gain = cfg_mon.data[5:0];
          default: ;
        endcase
      end
    end
    pending    <= cmd_backlog.size();
    fail_count <= errors;
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import sxc_pkg::*;

  // Pause after the last word before touching config.
  localparam int SETTLE_CYCLES   = 16;
  localparam int TAIL_CYCLES     = 32;
  localparam int RANDOM_PHASES   = 6;
  localparam int ITEMS_PER_PHASE = 92;
  localparam int RAW_MAX         = 4095;
  localparam int CFG_DATA_MAX    = 2047;

  // Index past the register file: the write must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  typedef enum int {YAW_ANY, YAW_IN_BAND, YAW_OUT_BAND} yaw_mode_t;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;

  // Mirror of the centre and effective throttle floor, used only to aim stimulus.
  int   cur_centre;
  int   cur_mc_eff;

  // Calm stretches: no idling on that side while set.
  bit   src_calm;
  bit   sink_calm;

  sxc_in_if  in_ch();
  sxc_out_if out_ch();
  sxc_cfg_if cfg_ch();

  stick_expo_command_shaper_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  shaper_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_mon    (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #1_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Offer one frame word: idle a random number of cycles first, then hold
  // valid until the block takes the word. Keep valid high when no gap is drawn
  // so back-to-back words never see valid drop and rise in one step.
  task automatic send_frame(input int roll, input int pitch, input int yaw, input int thr,
                            input int hold, input int heading);
    int gap;
    gap = src_calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.roll_raw     <= roll[RAW_W-1:0];
    in_ch.pitch_raw    <= pitch[RAW_W-1:0];
    in_ch.yaw_raw      <= yaw[RAW_W-1:0];
    in_ch.throttle_raw <= thr[RAW_W-1:0];
    in_ch.alt_hold     <= hold[0];
    in_ch.heading_deg  <= heading[HEAD_W-1:0];
    do @(posedge clk); while (!in_ch.ready);
    if ($urandom_range(0, 39) == 0) src_calm = !src_calm;
  endtask

  // Hold a config word until it is taken; the caller drops valid after a batch.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // Drop valid and wait until every queued frame has come out, then let the
  // pipeline drain for the latency.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_setting(input int expo, input int rate, input int centre,
                               input int mc, input int gain);
    settle();
    write_reg(REG_EXPO_AMOUNT, expo);
    write_reg(REG_RATE_AMOUNT, rate);
    write_reg(REG_CENTRE_WIDTH, centre);
    write_reg(REG_MIN_CHECK, mc);
    write_reg(REG_HEADING_GAIN, gain);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    cur_centre = int'(centre[CFG_DATA_W-1:0]);
    cur_mc_eff = int'(mc[CFG_DATA_W-1:0]);
    if (cur_mc_eff > int'(THR_MAX)) cur_mc_eff = int'(THR_MAX);
  endtask

  function automatic int near(input int mid, input int span);
    int v;
    v = mid + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > RAW_MAX) v = RAW_MAX;
    return v;
  endfunction

  // Mostly sweep the curve around centre; sometimes hit centre or the full field.
  function automatic int pick_stick();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, RAW_MAX);
      1:       return cur_centre;
      default: return near(cur_centre, 650);
    endcase
  endfunction

  task automatic random_frame(input yaw_mode_t mode);
    int yaw, thr, heading, off;
    case (mode)
      YAW_IN_BAND: yaw = near(cur_centre, int'(YAW_DEAD) - 1);
      YAW_OUT_BAND: begin
        off = $urandom_range(int'(YAW_DEAD), 600);
        yaw = (cur_centre >= off && $urandom_range(0, 1) == 1) ? cur_centre - off
                                                                : cur_centre + off;
      end
      default: yaw = $urandom_range(0, RAW_MAX);
    endcase

    if (mode == YAW_ANY) begin
      case ($urandom_range(0, 3))
        0:       thr = $urandom_range(0, RAW_MAX);
        1:       thr = near(cur_mc_eff, 3);
        default: thr = $urandom_range(800, 2200);
      endcase
    end else begin
      // Mostly keep throttle above the floor so the heading-hold path engages.
      thr = ($urandom_range(0, 4) == 0) ? near(cur_mc_eff, 3)
                                        : cur_mc_eff + int'($urandom_range(1, 300));
    end

    heading = ($urandom_range(0, 6) == 0) ? int'($urandom_range(0, 511)) - 256
                                          : int'($urandom_range(0, 360)) - 180;
    send_frame(pick_stick(), pick_stick(), yaw, thr, ($urandom_range(0, 4) == 0), heading);
  endtask

  // Receiver: draw a stall per word, then hold ready until a word is taken.
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    sink_calm = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = sink_calm ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if ($urandom_range(0, 49) == 0) sink_calm = !sink_calm;
    end
  end

  initial begin
    int  items;
    int  run;
    bit  paused;

    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.roll_raw     <= '0;
    in_ch.pitch_raw    <= '0;
    in_ch.yaw_raw      <= '0;
    in_ch.throttle_raw <= '0;
    in_ch.alt_hold     <= 1'b0;
    in_ch.heading_deg  <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= '0;
    cfg_ch.data        <= '0;
    src_calm   = 1'b0;
    cur_centre = int'(CFG_RESET.centre_width);
    cur_mc_eff = int'(CFG_RESET.min_check);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset config, zero gain. Open with altitude hold so the throttle word
    // still carries its reset value, then walk the stick and throttle extremes.
    send_frame(1500, 1500, 1500, 1500, 1, 0);
    send_frame(0, RAW_MAX, 0, RAW_MAX, 1, -180);
    send_frame(0, RAW_MAX, RAW_MAX, 0, 0, 180);
    send_frame(RAW_MAX, 0, 1500, RAW_MAX, 0, 0);
    // Exactly on centre, one off either side; throttle equal to the floor.
    send_frame(1500, 1499, 1501, 1100, 0, 0);
    // Segment boundary, yaw right on the dead-band edge.
    send_frame(1600, 1400, 1430, 1101, 0, 0);
    // Yaw just inside the dead band on both sides.
    send_frame(1550, 1450, 1431, 1101, 0, -256);
    send_frame(1999, 1001, 1569, 2000, 1, 255);
    // Full deflection exactly, and one past it.
    send_frame(2000, 1000, 1000, 2001, 0, -1);
    send_frame(2001, 999, 2001, 1099, 0, 1);

    // Heading hold with a live gain: load the held heading, then wrap the error.
    apply_setting(65, 90, 1500, 1100, 40);
    send_frame(1500, 1500, 1000, 1500, 0, 170);
    send_frame(1700, 1300, 1500, 1500, 0, -170);
    send_frame(1500, 1500, 1520, 1500, 1, 179);
    send_frame(1500, 1500, 2000, 1500, 0, 0);
    send_frame(1500, 1500, 1500, 1500, 0, -180);
    send_frame(1500, 1500, 1500, 1500, 0, 180);
    // Headings outside the half turn: errors beyond one wrap.
    send_frame(1500, 1500, 0, 1500, 0, -256);
    send_frame(1500, 1500, 1500, 1500, 0, 255);
    send_frame(1500, 1500, RAW_MAX, 1500, 0, 255);
    send_frame(1500, 1500, 1500, 1500, 0, -256);

    // All-ones data: expo and floor above range, centre out of range, max gain.
    apply_setting(CFG_DATA_MAX, CFG_DATA_MAX, CFG_DATA_MAX, CFG_DATA_MAX, CFG_DATA_MAX);
    send_frame(0, RAW_MAX, 2047, RAW_MAX, 0, 100);
    send_frame(RAW_MAX, 2046, 2046, 2001, 0, -100);

    // Flat curve, zero centre, floor 900; then a write to an unused index.
    apply_setting(0, 0, 0, 900, 1);
    write_reg(REG_SPARE, CFG_DATA_MAX);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    send_frame(0, 0, 0, 899, 0, 0);
    send_frame(RAW_MAX, 450, 69, 901, 0, 50);
    send_frame(250, 350, RAW_MAX, RAW_MAX, 0, -50);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: apply_setting(65, 90, 1500, 1100, 0);
        1: apply_setting(0, 0, 1000, 900, 0);
        2: apply_setting(100, 255, 2000, 1999, 63);
        3: apply_setting(127, 255, 1500, 2047, 63);
        default: apply_setting($urandom_range(0, CFG_DATA_MAX), $urandom_range(0, CFG_DATA_MAX),
                               $urandom_range(0, CFG_DATA_MAX), $urandom_range(0, CFG_DATA_MAX),
                               $urandom_range(0, CFG_DATA_MAX));
      endcase
      items  = 0;
      paused = 1'b0;
      while (items < ITEMS_PER_PHASE) begin
        // Once, mid-run: hold off the sender until the backlog is empty.
        if (ph == 2 && !paused && items >= ITEMS_PER_PHASE / 2) begin
          settle();
          paused = 1'b1;
        end
        if ($urandom_range(0, 9) < 8) begin
          // Load the held heading, then run frames through the dead band.
          run = $urandom_range(1, 6);
          random_frame(YAW_OUT_BAND);
          items++;
          repeat (run) begin
            random_frame(YAW_IN_BAND);
            items++;
          end
        end else begin
          random_frame(YAW_ANY);
          items++;
        end
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sxc_pkg.sv
rtl/sxc_if.sv
rtl/sxc_front.sv
rtl/sxc_queue.sv
rtl/sxc_back.sv
rtl/stick_expo_command_shaper_unit.sv
dv/shaper_checker.sv
dv/tb.sv
